// ===== rtl/fdse_pkg.sv =====
// Shared types, constants and codes for the fractional divider shift encoder.
package fdse_pkg;

  // Field widths
  localparam int ADDR_W  = 8;
  localparam int BYTE_W  = 8;
  localparam int INT_W   = 12;
  localparam int FRAC_W  = 20;
  localparam int SHIFT_W = 32;
  localparam int STEP_W  = 24;
  localparam int P1_W    = 18;
  localparam int P2_W    = 20;

  // Serial divider: 48-bit dividend, 24-bit divisor, one quotient bit a cycle
  localparam int DIV_NUM_W = 48;
  localparam int DIV_DEN_W = 24;
  localparam int DIV_CNT_W = $clog2(DIV_NUM_W + 1);

  // Item queue between front and back
  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  // Divider defaults and PLL register blocks
  localparam int FRAC_DENOM_DEF    = 1048575;
  localparam int PLLA_BASE_REG_DEF = 26;
  localparam int PLLB_BASE_REG_DEF = 34;

  // Configuration register reset values
  localparam logic [STEP_W-1:0] STEP_RST   = 24'd65536;
  localparam logic [FRAC_W-1:0] CENTER_RST = 20'd500000;
  localparam logic [FRAC_W-1:0] FRAC_MAX   = 20'hFFFFF;

  // Encoding offsets
  localparam logic [P1_W-1:0] P1_OFFSET = 18'd512;

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_STEP   = 2'd0,
    CFG_CENTER = 2'd1,
    CFG_READY  = 2'd2
  } cfg_idx_t;

  // Action codes
  typedef enum logic {
    ACT_SHIFT = 1'b0,
    ACT_FULL  = 1'b1
  } action_t;

  // Divider targets
  typedef enum logic [1:0] {
    TGT_MS   = 2'd0,
    TGT_PLLA = 2'd1,
    TGT_PLLB = 2'd2,
    TGT_NONE = 2'd3
  } target_t;

  // Classified item as it travels through the queue
  typedef struct packed {
    action_t              action;
    target_t              target;
    logic [ADDR_W-1:0]    base;
    logic [INT_W-1:0]     ipart;
    logic [FRAC_W-1:0]    fpart;
    logic                 neg;
    logic [SHIFT_W-1:0]   mag;
  } item_t;

  // Queue status
  typedef struct packed {
    logic               full;
    logic               empty;
    logic [Q_CNT_W-1:0] count;
  } q_stat_t;

  // Divider request and response
  typedef struct packed {
    logic                 start;
    logic [DIV_NUM_W-1:0] num;
    logic [DIV_DEN_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic                 busy;
    logic                 done;
    logic [DIV_NUM_W-1:0] quot;
  } div_rsp_t;

  // Back end sequencer states
  typedef enum logic [2:0] {
    BK_IDLE,
    BK_QDIV,
    BK_SHIFT,
    BK_ENC,
    BK_REM,
    BK_EMIT
  } bk_state_t;

endpackage

// ===== rtl/fdse_front.sv =====
// Input stage: accepts items, drops shifts while not ready, forms offset magnitude.
module fdse_front (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic                    in_action,
  input  logic [1:0]              in_divider_target,
  input  logic [7:0]              in_base_register,
  input  logic [11:0]             in_integer_part,
  input  logic [19:0]             in_fraction_part,
  input  logic signed [31:0]      in_shift_hz,
  input  logic                    ready_cfg,
  input  logic                    q_full,
  output logic                    q_push,
  output fdse_pkg::item_t         q_item
);
  import fdse_pkg::*;

  logic  valid_r, valid_nxt;
  item_t item_r, item_nxt;
  logic  accept;
  logic  neg;

  assign q_push   = valid_r && !q_full;
  assign in_ready = !valid_r || !q_full;
  assign accept   = in_valid && in_ready;
  assign q_item   = item_r;
  assign neg      = in_shift_hz[SHIFT_W-1];

  // Classify: a shift write while not set up causes nothing and is dropped here
  always_comb begin
    valid_nxt = valid_r && !q_push;
    item_nxt  = item_r;
    if (accept) begin
      item_nxt.action = action_t'(in_action);
      item_nxt.target = target_t'(in_divider_target);
      item_nxt.base   = in_base_register;
      item_nxt.ipart  = in_integer_part;
      item_nxt.fpart  = in_fraction_part;
      item_nxt.neg    = neg;
      item_nxt.mag    = neg ? (~in_shift_hz + 32'sd1) : in_shift_hz;
      valid_nxt       = (in_action == ACT_FULL) || ready_cfg;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    item_r <= item_nxt;
  end

endmodule

// ===== rtl/fdse_queue.sv =====
// Short item queue between the front and back parts.
module fdse_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  fdse_pkg::item_t   push_item,
  input  logic              pop,
  output fdse_pkg::item_t   head,
  output fdse_pkg::q_stat_t stat
);
  import fdse_pkg::*;

  item_t              slot_r [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [Q_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [Q_CNT_W-1:0] cnt_r, cnt_nxt;
  logic               do_push, do_pop;

  assign stat.full  = (cnt_r == Q_CNT_W'(Q_DEPTH));
  assign stat.empty = (cnt_r == '0);
  assign stat.count = cnt_r;
  assign head       = slot_r[rd_ptr_r];
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;

  // Pointer wrap at the queue depth
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    case ({do_push, do_pop})
      2'b10:   cnt_nxt = cnt_r + 1'b1;
      2'b01:   cnt_nxt = cnt_r - 1'b1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

// ===== rtl/fdse_div.sv =====
// Restoring serial divider, one quotient bit per cycle.
module fdse_div (
  input  logic               clk,
  input  logic               rst_n,
  input  fdse_pkg::div_req_t req,
  output fdse_pkg::div_rsp_t rsp
);
  import fdse_pkg::*;

  logic [DIV_NUM_W-1:0] num_r, num_nxt;
  logic [DIV_DEN_W-1:0] rem_r, rem_nxt;
  logic [DIV_DEN_W-1:0] den_r, den_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [DIV_DEN_W:0]   rem_sh;
  logic                 ge;

  // Trial subtract of the shifted partial remainder
  assign rem_sh = {rem_r, num_r[DIV_NUM_W-1]};
  assign ge     = (rem_sh >= {1'b0, den_r});

  always_comb begin
    num_nxt  = num_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (req.start) begin
      num_nxt  = req.num;
      rem_nxt  = '0;
      den_nxt  = req.den;
      cnt_nxt  = DIV_CNT_W'(DIV_NUM_W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      num_nxt = {num_r[DIV_NUM_W-2:0], ge};
      rem_nxt = ge ? DIV_DEN_W'(rem_sh - {1'b0, den_r}) : DIV_DEN_W'(rem_sh);
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == DIV_CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    num_r <= num_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
  end

  assign rsp.busy = busy_r;
  assign rsp.done = done_r;
  assign rsp.quot = num_r;

endmodule

// ===== rtl/fdse_back.sv =====
// Back end: scales shift offsets, encodes dividers, keeps PLL state, emits register bytes.
module fdse_back #(
  parameter int FRAC_DENOM    = fdse_pkg::FRAC_DENOM_DEF,
  parameter int PLLA_BASE_REG = fdse_pkg::PLLA_BASE_REG_DEF,
  parameter int PLLB_BASE_REG = fdse_pkg::PLLB_BASE_REG_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  fdse_pkg::q_stat_t             q_stat,
  input  fdse_pkg::item_t               q_head,
  output logic                          q_pop,
  input  logic [fdse_pkg::STEP_W-1:0]   step_hz_q16,
  input  logic [fdse_pkg::FRAC_W-1:0]   center_fraction,
  output fdse_pkg::div_req_t            div_req,
  input  fdse_pkg::div_rsp_t            div_rsp,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [7:0]                    out_register_address,
  output logic [7:0]                    out_data_byte,
  output logic                          out_last
);
  import fdse_pkg::*;

  localparam logic [P2_W-1:0]      P3     = P2_W'(FRAC_DENOM);
  localparam logic [ADDR_W-1:0]    PLLA_A = ADDR_W'(PLLA_BASE_REG);
  localparam logic [ADDR_W-1:0]    PLLB_A = ADDR_W'(PLLB_BASE_REG);
  localparam logic [ADDR_W-1:0]    BLK_HI = ADDR_W'(4);

  // Reciprocal of the fixed denominator, exact for every 128*b
  localparam int                   ENC_X_W = FRAC_W + 7;
  localparam int                   ENC_P_W = 2 * ENC_X_W + 1;
  localparam int                   REC_L   = $clog2(FRAC_DENOM);
  localparam int                   REC_S   = ENC_X_W + REC_L;
  localparam logic [63:0]          REC_M64 = ((64'd1 << REC_S) + 64'(FRAC_DENOM) - 64'd1)
                                             / 64'(FRAC_DENOM);
  localparam logic [ENC_X_W:0]     REC_M   = REC_M64[ENC_X_W:0];
  localparam logic [ENC_X_W-1:0]   DEN_X   = ENC_X_W'(FRAC_DENOM);

  bk_state_t            state_r, state_nxt;
  logic [INT_W-1:0]     pa_int_r, pa_int_nxt, pb_int_r, pb_int_nxt;
  logic [FRAC_W-1:0]    pa_frac_r, pa_frac_nxt, pb_frac_r, pb_frac_nxt;
  logic                 use_b_r, use_b_nxt;
  logic                 neg_r, neg_nxt;
  logic [DIV_NUM_W-1:0] q_r, q_nxt;
  logic [INT_W-1:0]     a_r, a_nxt;
  logic [FRAC_W-1:0]    eb_r, eb_nxt;
  logic [ENC_X_W-1:0]   encq_r, encq_nxt;
  logic [ADDR_W-1:0]    origin_r, origin_nxt;
  logic [2:0]           k_r, k_nxt;
  logic [P1_W-1:0]      p1_r, p1_nxt;
  logic [P2_W-1:0]      p2_r, p2_nxt;
  logic                 ov_r, ov_nxt;
  logic [ADDR_W-1:0]    oa_r, oa_nxt;
  logic [BYTE_W-1:0]    od_r, od_nxt;
  logic                 ol_r, ol_nxt;

  logic [FRAC_W-1:0]    limit, qc, newb, stored;
  logic [FRAC_W:0]      sum;
  logic                 out_load;
  logic [ENC_X_W-1:0]   enc_x, enc_cq;
  logic [ENC_P_W-1:0]   enc_prod;

  // Register byte k of a divider block
  function automatic logic [BYTE_W-1:0] block_byte(input logic [2:0] k,
                                                   input logic [P1_W-1:0] p1,
                                                   input logic [P2_W-1:0] p2);
    logic [BYTE_W-1:0] b;
    case (k)
      3'd0:    b = P3[15:8];
      3'd1:    b = P3[7:0];
      3'd2:    b = {6'b0, p1[17:16]};
      3'd3:    b = p1[15:8];
      3'd4:    b = p1[7:0];
      3'd5:    b = {P3[19:16], p2[19:16]};
      3'd6:    b = p2[15:8];
      default: b = p2[7:0];
    endcase
    return b;
  endfunction

  // New fraction from the clamped count around the center
  always_comb begin
    limit  = (center_fraction >= FRAC_W'(1)) ? center_fraction - 1'b1 : '0;
    qc     = (q_r > DIV_NUM_W'(limit)) ? limit : q_r[FRAC_W-1:0];
    sum    = neg_r ? {1'b0, center_fraction} - {1'b0, qc}
                   : {1'b0, center_fraction} + {1'b0, qc};
    newb   = sum[FRAC_W] ? FRAC_MAX : sum[FRAC_W-1:0];
    stored = use_b_r ? pb_frac_r : pa_frac_r;
  end

  // Encode: quotient of 128*b by the denominator, then the remainder
  assign enc_x    = {eb_r, 7'b0};
  assign enc_prod = ENC_P_W'(enc_x) * ENC_P_W'(REC_M);
  assign enc_cq   = DEN_X * encq_r;

  assign out_load = !ov_r || out_ready;

  // Sequencer
  always_comb begin
    state_nxt   = state_r;
    pa_int_nxt  = pa_int_r;
    pb_int_nxt  = pb_int_r;
    pa_frac_nxt = pa_frac_r;
    pb_frac_nxt = pb_frac_r;
    use_b_nxt   = use_b_r;
    neg_nxt     = neg_r;
    q_nxt       = q_r;
    a_nxt       = a_r;
    eb_nxt      = eb_r;
    encq_nxt    = encq_r;
    origin_nxt  = origin_r;
    k_nxt       = k_r;
    p1_nxt      = p1_r;
    p2_nxt      = p2_r;
    ov_nxt      = ov_r && !out_ready;
    oa_nxt      = oa_r;
    od_nxt      = od_r;
    ol_nxt      = ol_r;
    q_pop       = 1'b0;
    div_req     = '0;
    unique case (state_r)
      BK_IDLE: begin
        if (!q_stat.empty) begin
          q_pop     = 1'b1;
          use_b_nxt = (q_head.target == TGT_PLLB);
          neg_nxt   = q_head.neg;
          if (q_head.action == ACT_FULL) begin
            eb_nxt     = q_head.fpart;
            a_nxt      = q_head.ipart;
            origin_nxt = q_head.base;
            k_nxt      = 3'd0;
            if (q_head.target == TGT_PLLA) begin
              pa_int_nxt  = q_head.ipart;
              pa_frac_nxt = q_head.fpart;
            end else if (q_head.target == TGT_PLLB) begin
              pb_int_nxt  = q_head.ipart;
              pb_frac_nxt = q_head.fpart;
            end
            state_nxt = BK_ENC;
          end else if (q_head.mag == '0) begin
            q_nxt     = '0;
            state_nxt = BK_SHIFT;
          end else if (step_hz_q16 == '0) begin
            // zero step: unbounded quotient, clamps to the limit
            q_nxt     = '1;
            state_nxt = BK_SHIFT;
          end else begin
            div_req.start = 1'b1;
            div_req.num   = {q_head.mag, 16'b0};
            div_req.den   = step_hz_q16;
            state_nxt     = BK_QDIV;
          end
        end
      end
      BK_QDIV: begin
        if (div_rsp.done) begin
          q_nxt     = div_rsp.quot;
          state_nxt = BK_SHIFT;
        end
      end
      BK_SHIFT: begin
        if (newb == stored) begin
          state_nxt = BK_IDLE;
        end else begin
          eb_nxt     = newb;
          a_nxt      = use_b_r ? pb_int_r : pa_int_r;
          origin_nxt = use_b_r ? PLLB_A : PLLA_A;
          k_nxt      = 3'd4;
          if (use_b_r) begin
            pb_frac_nxt = newb;
          end else begin
            pa_frac_nxt = newb;
          end
          state_nxt = BK_ENC;
        end
      end
      BK_ENC: begin
        encq_nxt  = ENC_X_W'(enc_prod >> REC_S);
        state_nxt = BK_REM;
      end
      BK_REM: begin
        p1_nxt    = P1_W'({a_r, 7'b0}) + encq_r[P1_W-1:0] - P1_OFFSET;
        p2_nxt    = P2_W'(enc_x - enc_cq);
        state_nxt = BK_EMIT;
      end
      BK_EMIT: begin
        if (out_load) begin
          ov_nxt = 1'b1;
          oa_nxt = (k_r >= 3'd4) ? origin_r + BLK_HI + ADDR_W'(k_r - 3'd4)
                                 : origin_r + ADDR_W'(k_r);
          od_nxt = block_byte(k_r, p1_r, p2_r);
          ol_nxt = (k_r == 3'd7);
          k_nxt  = k_r + 1'b1;
          if (k_r == 3'd7) begin
            state_nxt = BK_IDLE;
          end
        end
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= BK_IDLE;
      ov_r      <= 1'b0;
      pa_int_r  <= '0;
      pb_int_r  <= '0;
      pa_frac_r <= '0;
      pb_frac_r <= '0;
    end else begin
      state_r   <= state_nxt;
      ov_r      <= ov_nxt;
      pa_int_r  <= pa_int_nxt;
      pb_int_r  <= pb_int_nxt;
      pa_frac_r <= pa_frac_nxt;
      pb_frac_r <= pb_frac_nxt;
    end
    use_b_r  <= use_b_nxt;
    neg_r    <= neg_nxt;
    q_r      <= q_nxt;
    a_r      <= a_nxt;
    eb_r     <= eb_nxt;
    encq_r   <= encq_nxt;
    origin_r <= origin_nxt;
    k_r      <= k_nxt;
    p1_r     <= p1_nxt;
    p2_r     <= p2_nxt;
    oa_r     <= oa_nxt;
    od_r     <= od_nxt;
    ol_r     <= ol_nxt;
  end

  assign out_valid            = ov_r;
  assign out_register_address = oa_r;
  assign out_data_byte        = od_r;
  assign out_last             = ol_r;

endmodule

// ===== rtl/fractional_divider_shift_encoder_unit.sv =====
// Path: a full write goes through the input register, the queue, the reciprocal multiply
// and the remainder to its first byte, then one byte a cycle while out_ready takes them; a
// shift write first has a 48-step divide by the step, skipped for a zero offset or step.
// The back end ends one item's bytes before it pops the next; the queue holds more meanwhile.
// Reset: synchronous active-low rst_n clears queue, sequencer, stored PLL values
// and loads the configuration defaults; shift writes are ignored until ready_cfg is set.
module fractional_divider_shift_encoder_unit #(
  parameter int FRAC_DENOM    = fdse_pkg::FRAC_DENOM_DEF,
  parameter int PLLA_BASE_REG = fdse_pkg::PLLA_BASE_REG_DEF,
  parameter int PLLB_BASE_REG = fdse_pkg::PLLB_BASE_REG_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_action,
  input  logic [1:0]         in_divider_target,
  input  logic [7:0]         in_base_register,
  input  logic [11:0]        in_integer_part,
  input  logic [19:0]        in_fraction_part,
  input  logic signed [31:0] in_shift_hz,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [7:0]         out_register_address,
  output logic [7:0]         out_data_byte,
  output logic               out_last,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [23:0]        cfg_data
);
  import fdse_pkg::*;

  logic [STEP_W-1:0] step_r, step_nxt;
  logic [FRAC_W-1:0] center_r, center_nxt;
  logic              rdy_r, rdy_nxt;

  logic     q_push, q_pop;
  item_t    q_in, q_head;
  q_stat_t  q_stat;
  div_req_t div_req;
  div_rsp_t div_rsp;

  // Configuration registers
  assign cfg_ready = 1'b1;

  always_comb begin
    step_nxt   = step_r;
    center_nxt = center_r;
    rdy_nxt    = rdy_r;
    if (cfg_valid && cfg_ready) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_STEP:   step_nxt   = cfg_data;
        CFG_CENTER: center_nxt = cfg_data[FRAC_W-1:0];
        CFG_READY:  rdy_nxt    = cfg_data[0];
        default:    ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r   <= STEP_RST;
      center_r <= CENTER_RST;
      rdy_r    <= 1'b0;
    end else begin
      step_r   <= step_nxt;
      center_r <= center_nxt;
      rdy_r    <= rdy_nxt;
    end
  end

  fdse_front u_front (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_action         (in_action),
    .in_divider_target (in_divider_target),
    .in_base_register  (in_base_register),
    .in_integer_part   (in_integer_part),
    .in_fraction_part  (in_fraction_part),
    .in_shift_hz       (in_shift_hz),
    .ready_cfg         (rdy_r),
    .q_full            (q_stat.full),
    .q_push            (q_push),
    .q_item            (q_in)
  );

  fdse_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (q_in),
    .pop       (q_pop),
    .head      (q_head),
    .stat      (q_stat)
  );

  fdse_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  fdse_back #(
    .FRAC_DENOM    (FRAC_DENOM),
    .PLLA_BASE_REG (PLLA_BASE_REG),
    .PLLB_BASE_REG (PLLB_BASE_REG)
  ) u_back (
    .clk                  (clk),
    .rst_n                (rst_n),
    .q_stat               (q_stat),
    .q_head               (q_head),
    .q_pop                (q_pop),
    .step_hz_q16          (step_r),
    .center_fraction      (center_r),
    .div_req              (div_req),
    .div_rsp              (div_rsp),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_register_address (out_register_address),
    .out_data_byte        (out_data_byte),
    .out_last             (out_last)
  );

  // Front never pushes into a full queue
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_stat.full)
    else $error("item pushed into full queue");

  // Back never pops an empty queue
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_stat.empty)
    else $error("item popped from empty queue");

  // Divider is only started when idle
  a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
    div_req.start |-> !div_rsp.busy)
    else $error("divider restarted while busy");

  // Queue occupancy stays within its depth
  a_q_count: assert property (@(posedge clk) disable iff (!rst_n)
    q_stat.count <= Q_CNT_W'(Q_DEPTH))
    else $error("queue count out of range");

endmodule

// ===== tb/tb.sv =====
// Testbench for the fractional divider shift encoder: directed and random items vs. a predictor.
`timescale 1ns / 100ps

module tb;
  import fdse_pkg::*;

  localparam int LIMIT_CYCLES  = 600000;
  localparam int SETTLE_CYCLES = 600;
  localparam logic [19:0] DENOM    = 20'(FRAC_DENOM_DEF);
  localparam logic [7:0]  PLLA_REG = 8'(PLLA_BASE_REG_DEF);
  localparam logic [7:0]  PLLB_REG = 8'(PLLB_BASE_REG_DEF);

  // One divider command as offered on the input channel
  typedef struct {
    action_t            action;
    target_t            target;
    logic [7:0]         base;
    logic [11:0]        ipart;
    logic [19:0]        fpart;
    logic signed [31:0] shift;
  } div_cmd_t;

  // One register write as seen on the result channel
  typedef struct {
    logic [7:0] addr;
    logic [7:0] data;
    logic       last;
  } reg_write_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  action_t            in_action = ACT_SHIFT;
  target_t            in_divider_target = TGT_MS;
  logic [7:0]         in_base_register = '0;
  logic [11:0]        in_integer_part = '0;
  logic [19:0]        in_fraction_part = '0;
  logic signed [31:0] in_shift_hz = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [7:0]         out_register_address;
  logic [7:0]         out_data_byte;
  logic               out_last;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  cfg_idx_t           cfg_index = CFG_STEP;
  logic [23:0]        cfg_data = '0;

  // Predictor state: configuration and remembered PLL settings (0 = A, 1 = B)
  logic [23:0] step_q16;
  logic [19:0] center;
  logic        ready_on;
  logic [11:0] pll_int [2];
  logic [19:0] pll_frac [2];

  reg_write_t         pending_writes[$];
  logic signed [31:0] last_shift;
  int                 errors, items_sent, bytes_checked, silent_shifts, settings_used;
  int                 cycle_count, hold_left;
  bit                 idle_on = 1'b1;

  fractional_divider_shift_encoder_unit dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .in_action            (in_action),
    .in_divider_target    (in_divider_target),
    .in_base_register     (in_base_register),
    .in_integer_part      (in_integer_part),
    .in_fraction_part     (in_fraction_part),
    .in_shift_hz          (in_shift_hz),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_register_address (out_register_address),
    .out_data_byte        (out_data_byte),
    .out_last             (out_last),
    .cfg_valid            (cfg_valid),
    .cfg_ready            (cfg_ready),
    .cfg_index            (cfg_index),
    .cfg_data             (cfg_data)
  );

  always #10 clk = ~clk;

  // Run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == LIMIT_CYCLES) begin
      $display("Timeout after %0d cycles, %0d bytes still expected",
               cycle_count, pending_writes.size());
      $display("TEST FAILED");
      $finish;
    end
  end

  // Result receiver: long hold-off when requested, else random stalls while idling is on
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left--;
    end else begin
      out_ready <= !(idle_on && $urandom_range(99) < 38);
    end
  end

  task automatic report_mismatch(input string what);
    $display("ERROR at %0t: %s", $time, what);
    errors++;
  endtask

  // Compare each accepted byte with the oldest expected one
  always @(posedge clk) begin : check_results
    reg_write_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_writes.size() == 0) begin
        report_mismatch($sformatf("unexpected byte addr %0d data %02h",
                                  out_register_address, out_data_byte));
      end else begin
        want = pending_writes.pop_front();
        bytes_checked++;
        if (out_register_address !== want.addr)
          report_mismatch($sformatf("address %0d, expected %0d",
                                    out_register_address, want.addr));
        if (out_data_byte !== want.data)
          report_mismatch($sformatf("data %02h at addr %0d, expected %02h",
                                    out_data_byte, want.addr, want.data));
        if (out_last !== want.last)
          report_mismatch($sformatf("last %b at addr %0d, expected %b",
                                    out_last, want.addr, want.last));
      end
    end
  end

  // P1/P2 of a + b/DENOM; P1 wraps to 18 bits
  function automatic void divider_params(input logic [11:0] a, input logic [19:0] b,
                                         output logic [17:0] p1, output logic [19:0] p2);
    longint q;
    q  = (longint'(b) * 128) / longint'(DENOM);
    p1 = 18'(longint'(a) * 128 + q - 512);
    p2 = 20'(longint'(b) * 128 - longint'(DENOM) * q);
  endfunction

  // Expected register writes of one accepted item, with state update
  function automatic void predict_writes(input div_cmd_t c);
    logic [17:0] p1;
    logic [19:0] p2, newb;
    logic [31:0] mag;
    logic [7:0]  bytes [8];
    logic [7:0]  first_reg;
    longint      cnt, limit, sum;
    int          sel, first;
    reg_write_t  w;
    if (c.action == ACT_FULL) begin
      divider_params(c.ipart, c.fpart, p1, p2);
      if (c.target == TGT_PLLA) begin
        pll_int[0] = c.ipart;
        pll_frac[0] = c.fpart;
      end else if (c.target == TGT_PLLB) begin
        pll_int[1] = c.ipart;
        pll_frac[1] = c.fpart;
      end
      first = 0;
      first_reg = c.base;
    end else begin
      if (!ready_on) begin
        silent_shifts++;
        return;
      end
      sel = (c.target == TGT_PLLB);
      mag = c.shift[31] ? 32'(-c.shift) : 32'(c.shift);
      limit = (center >= 1) ? longint'(center) - 1 : 0;
      if (mag == 0) cnt = 0;
      else if (step_q16 == 0) cnt = limit;
      else cnt = (longint'(mag) << 16) / longint'(step_q16);
      if (cnt > limit) cnt = limit;
      sum = c.shift[31] ? longint'(center) - cnt : longint'(center) + cnt;
      if (sum > longint'(FRAC_MAX)) sum = longint'(FRAC_MAX);
      newb = 20'(sum);
      // unchanged fraction: nothing to rewrite
      if (newb == pll_frac[sel]) begin
        silent_shifts++;
        return;
      end
      divider_params(pll_int[sel], newb, p1, p2);
      pll_frac[sel] = newb;
      first = 4;
      first_reg = sel ? PLLB_REG : PLLA_REG;
    end
    bytes = '{DENOM[15:8], DENOM[7:0], {6'd0, p1[17:16]}, p1[15:8], p1[7:0],
              {DENOM[19:16], p2[19:16]}, p2[15:8], p2[7:0]};
    for (int k = first; k < 8; k++) begin
      w.addr = 8'(first_reg + k);
      w.data = bytes[k];
      w.last = (k == 7);
      pending_writes.push_back(w);
    end
  endfunction

  // Offer one item and predict it once accepted; valid stays high for a following item
  task automatic send_item(input div_cmd_t c);
    while (idle_on && $urandom_range(99) < 38) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid          <= 1'b1;
    in_action         <= c.action;
    in_divider_target <= c.target;
    in_base_register  <= c.base;
    in_integer_part   <= c.ipart;
    in_fraction_part  <= c.fpart;
    in_shift_hz       <= c.shift;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_writes(c);
    items_sent++;
  endtask

  task automatic send_full(input target_t t, input logic [7:0] base,
                           input logic [11:0] a, input logic [19:0] b);
    div_cmd_t c;
    c = '{action: ACT_FULL, target: t, base: base, ipart: a, fpart: b,
          shift: $urandom};
    send_item(c);
  endtask

  task automatic send_shift(input target_t t, input logic signed [31:0] hz);
    div_cmd_t c;
    c = '{action: ACT_SHIFT, target: t, base: 8'($urandom), ipart: 12'($urandom),
          fpart: 20'($urandom), shift: hz};
    send_item(c);
  endtask

  // Stop offering, wait for all bytes, then let silent shift items finish
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_writes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // One register write; keep_valid holds valid for a following write
  task automatic cfg_write(input cfg_idx_t idx, input logic [23:0] value, input bit keep_valid);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      CFG_STEP:   step_q16 = value;
      CFG_CENTER: center = value[19:0];
      CFG_READY:  ready_on = value[0];
      default: ;
    endcase
    if (!keep_valid) cfg_valid <= 1'b0;
  endtask

  task automatic set_config(input logic [23:0] step, input logic [23:0] ctr,
                            input logic [23:0] rdy);
    wait_idle();
    cfg_write(CFG_STEP, step, 1'b1);
    cfg_write(CFG_CENTER, ctr, 1'b1);
    cfg_write(CFG_READY, rdy, 1'b0);
    settings_used++;
  endtask

  // Random item: mostly shifts against PLLs seeded by full writes
  function automatic div_cmd_t random_cmd();
    div_cmd_t c;
    int r;
    c.action = ($urandom_range(99) < 35) ? ACT_FULL : ACT_SHIFT;
    c.target = target_t'($urandom_range(3));
    c.base   = 8'($urandom);
    c.ipart  = ($urandom_range(9) == 0) ? 12'($urandom_range(4)) : 12'($urandom);
    c.fpart  = 20'($urandom);
    r = $urandom_range(3);
    case (r)
      0: c.shift = $signed($urandom_range(255)) * ($urandom_range(1) ? 1 : -1);
      1: c.shift = $signed($urandom_range(65535)) * ($urandom_range(1) ? 1 : -1);
      2: c.shift = $urandom;
      default: c.shift = last_shift;
    endcase
    if (c.action == ACT_SHIFT) last_shift = c.shift;
    return c;
  endfunction

  function automatic logic [23:0] random_step();
    case ($urandom_range(9))
      0: return 24'd0;
      1: return 24'hFFFFFF;
      2: return 24'd1;
      3, 4: return 24'($urandom);
      default: return 24'($urandom_range(1, 24'h40000));
    endcase
  endfunction

  function automatic logic [23:0] random_center();
    case ($urandom_range(9))
      0: return 24'($urandom_range(1));
      1: return 24'd1048574;
      2: return 24'hFFFFFF;
      default: return 24'($urandom);
    endcase
  endfunction

  // A dropped shift and full writes before the chip is marked ready, at the field extremes
  task automatic test_full_writes();
    send_shift(TGT_PLLA, 32'sd1000);
    send_full(TGT_MS, 8'd0, 12'd0, 20'd0);
    send_full(TGT_PLLA, 8'd255, 12'd4095, 20'd1048575);
    send_full(TGT_PLLB, PLLB_REG, 12'd36, 20'd524288);
    send_full(TGT_NONE, 8'h80, 12'd4, 20'd1);
    send_full(TGT_PLLA, PLLA_REG, 12'd40, 20'd0);
    wait_idle();
    // write to the unused index, then enable shifts
    cfg_write(cfg_idx_t'(2'd3), 24'($urandom), 1'b1);
    cfg_write(CFG_READY, 24'd1, 1'b0);
  endtask

  // Shift writes at the reset step and center
  task automatic test_shift_cases();
    send_shift(TGT_PLLA, 32'sd0);
    send_shift(TGT_PLLA, 32'sd0);
    send_shift(TGT_PLLB, 32'sd1000);
    send_shift(TGT_MS, -32'sd1000);
    send_shift(TGT_NONE, 32'h7FFFFFFF);
    send_shift(TGT_PLLB, 32'h80000000);
    send_shift(TGT_PLLB, -32'sd1);
  endtask

  // Zero step, overflowing fraction, small centers
  task automatic test_config_extremes();
    set_config(24'd0, 24'd1048574, 24'd1);
    send_shift(TGT_PLLA, 32'sd5);
    send_shift(TGT_PLLA, 32'sd0);
    send_shift(TGT_PLLB, -32'sd7);
    set_config(24'hFFFFFF, 24'd1, 24'hFFFFFF);
    send_shift(TGT_PLLA, 32'h7FFFFFFF);
    send_shift(TGT_PLLB, -32'sd100);
    set_config(24'd1, 24'hF00000, 24'd1);
    send_shift(TGT_PLLA, 32'sd3);
    set_config(24'd65536, 24'd500000, 24'd1);
  endtask

  // A stretch with no idling on either side
  task automatic test_back_to_back();
    idle_on = 1'b0;
    repeat (40) send_item(random_cmd());
    wait_idle();
    idle_on = 1'b1;
  endtask

  // Receiver holds off while items keep coming, then the sender drains
  task automatic test_backpressure();
    hold_left = 800;
    repeat (12) send_full(target_t'($urandom_range(3)), 8'($urandom), 12'($urandom),
                          20'($urandom));
    wait_idle();
  endtask

  task automatic test_random_mix();
    for (int ph = 0; ph < 6; ph++) begin
      set_config(random_step(), random_center(), ($urandom_range(9) < 8) ? 24'd1 : 24'd0);
      repeat (45) send_item(random_cmd());
    end
  endtask

  initial begin
    step_q16 = STEP_RST;
    center   = CENTER_RST;
    ready_on = 1'b0;
    pll_int  = '{default: '0};
    pll_frac = '{default: '0};
    last_shift = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    test_full_writes();
    test_shift_cases();
    test_config_extremes();
    test_back_to_back();
    test_backpressure();
    test_random_mix();

    wait_idle();
    $display("Sent %0d items (full and shift writes) over %0d register settings;",
             items_sent, settings_used);
    $display("checked %0d register bytes, %0d shift items correctly gave no bytes.",
             bytes_checked, silent_shifts);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("%0d mismatches", errors);
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ===== fractional_divider_shift_encoder_unit.f =====
rtl/fdse_pkg.sv
rtl/fdse_front.sv
rtl/fdse_queue.sv
rtl/fdse_div.sv
rtl/fdse_back.sv
rtl/fractional_divider_shift_encoder_unit.sv
tb/tb.sv
